>>> sv/plcu_pkg.sv
// Package for the periodic lattice coordinate unit: field widths, op,
// status and register codes, and the word types passed between stages.
// No dependencies.
`default_nettype none

package plcu_pkg;

   localparam int COORD_W   = 10;
   localparam int STEP_W    = 5;
   localparam int INDEX_W   = 30;
   localparam int DIST_W    = 22;
   localparam int SIZE_W    = 11;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] OP_MOVE     = 2'd0;
   localparam logic [1:0] OP_DIST     = 2'd1;
   localparam logic [1:0] OP_TO_COORD = 2'd2;
   localparam logic [1:0] OP_TO_INDEX = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_REJECT    = 2'd1;
   localparam logic [1:0] STAT_OUTSIDE   = 2'd2;
   localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_Z = 3'd5;

   typedef struct packed {
      logic [SIZE_W-1:0] size_x;
      logic [SIZE_W-1:0] size_y;
      logic [SIZE_W-1:0] size_z;
      logic              wrap_x;
      logic              wrap_y;
      logic              wrap_z;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [COORD_W-1:0] first_x;
      logic [COORD_W-1:0] first_y;
      logic [COORD_W-1:0] first_z;
      logic [STEP_W-1:0]  step_x;
      logic [STEP_W-1:0]  step_y;
      logic [STEP_W-1:0]  step_z;
      logic [COORD_W-1:0] second_x;
      logic [COORD_W-1:0] second_y;
      logic [COORD_W-1:0] second_z;
      logic [INDEX_W-1:0] linear_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [1:0]         status;
      logic [COORD_W-1:0] ox;
      logic [COORD_W-1:0] oy;
      logic [COORD_W-1:0] oz;
      logic [COORD_W-1:0] mag_x;
      logic [COORD_W-1:0] mag_y;
      logic [COORD_W-1:0] mag_z;
      logic [INDEX_W-1:0] linear_index;
   } front_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [1:0]         status;
      logic [COORD_W-1:0] ox;
      logic [COORD_W-1:0] oy;
      logic [COORD_W-1:0] oz;
      logic [SQ_W-1:0]    sq_x;
      logic [SQ_W-1:0]    sq_y;
      logic [SQ_W-1:0]    sq_z;
      logic               ovf;
   } mid_type;

endpackage

`default_nettype wire

>>> sv/plcu_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on plcu_pkg.
`default_nettype none

interface plcu_req_if;
   import plcu_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [COORD_W-1:0] first_x;
   logic [COORD_W-1:0] first_y;
   logic [COORD_W-1:0] first_z;
   logic [STEP_W-1:0]  step_x;
   logic [STEP_W-1:0]  step_y;
   logic [STEP_W-1:0]  step_z;
   logic [COORD_W-1:0] second_x;
   logic [COORD_W-1:0] second_y;
   logic [COORD_W-1:0] second_z;
   logic [INDEX_W-1:0] linear_index;

   modport source (output valid, op, first_x, first_y, first_z, step_x, step_y, step_z,
                   second_x, second_y, second_z, linear_index, input ready);
   modport sink (input valid, op, first_x, first_y, first_z, step_x, step_y, step_z,
                 second_x, second_y, second_z, linear_index, output ready);
endinterface

interface plcu_rsp_if;
   import plcu_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [COORD_W-1:0] out_x;
   logic [COORD_W-1:0] out_y;
   logic [COORD_W-1:0] out_z;
   logic [INDEX_W-1:0] out_index;
   logic [DIST_W-1:0]  dist_sq;

   modport source (output valid, status, out_x, out_y, out_z, out_index, dist_sq,
                   input ready);
   modport sink (input valid, status, out_x, out_y, out_z, out_index, dist_sq,
                 output ready);
endinterface

`default_nettype wire

>>> sv/periodic_lattice_coordinate_unit.sv
// Periodic lattice coordinate unit. Takes one request word per clock while
// not stalled and returns one response word per request, in order. Every op
// passes through the two bit-serial divider pipelines that split a linear
// index into coordinates, one quotient bit per stage. Throughput is one word
// per cycle; the pipeline holds only while a response waits on rsp.ready.
// The user must write size and wrap registers through the csr port only
// while no request is in flight; the block itself does not enforce this.
// Depends on plcu_pkg, plcu_if, plcu_front and plcu_divider.
`default_nettype none

module periodic_lattice_coordinate_unit #(
   parameter int MAX_DIM = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   plcu_req_if.sink                       req,
   plcu_rsp_if.source                     rsp,
   input  logic                           csr_wr_en,
   input  logic [plcu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [plcu_pkg::SIZE_W-1:0]    csr_wdata
);
   import plcu_pkg::*;

   localparam int SW     = $clog2(MAX_DIM + 1);
   localparam int CW     = (SW > COORD_W) ? SW : COORD_W;
   localparam int PW     = 2 * SW;
   localparam int OW     = ((3 * SW > INDEX_W) ? 3 * SW : INDEX_W) + 1;
   localparam int SIDE1W = $bits(mid_type);
   localparam int SIDE2W = SIDE1W + SW;

   function automatic logic [SW-1:0] eff_size(input logic [SIZE_W-1:0] sz);
      if (sz == '0) begin
         return SW'(1);
      end else if (32'(sz) > MAX_DIM) begin
         return SW'(MAX_DIM);
      end else begin
         return SW'(sz);
      end
   endfunction

   // configuration
   cfg_type       cfg_ff, cfg_in;
   logic [SW-1:0] nx, ny, nz;
   logic [PW-1:0] plane_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SIZE_X: cfg_in.size_x = csr_wdata;
            CSR_SIZE_Y: cfg_in.size_y = csr_wdata;
            CSR_SIZE_Z: cfg_in.size_z = csr_wdata;
            CSR_WRAP_X: cfg_in.wrap_x = csr_wdata[0];
            CSR_WRAP_Y: cfg_in.wrap_y = csr_wdata[0];
            CSR_WRAP_Z: cfg_in.wrap_z = csr_wdata[0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   assign nx = eff_size(cfg_ff.size_x);
   assign ny = eff_size(cfg_ff.size_y);
   assign nz = eff_size(cfg_ff.size_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '{size_x: SIZE_W'(1), size_y: SIZE_W'(1), size_z: SIZE_W'(1),
                       wrap_x: 1'b0, wrap_y: 1'b0, wrap_z: 1'b0};
         plane_ff <= PW'(1);
      end else begin
         cfg_ff   <= cfg_in;
         plane_ff <= PW'(ny) * PW'(nz);
      end
   end

   // whole pipeline advances unless the response word is stalled
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // stage 1: request register
   logic    s1_valid_ff;
   req_type s1_word_ff, s1_word_in;

   always_comb begin
      s1_word_in.op           = req.op;
      s1_word_in.first_x      = req.first_x;
      s1_word_in.first_y      = req.first_y;
      s1_word_in.first_z      = req.first_z;
      s1_word_in.step_x       = req.step_x;
      s1_word_in.step_y       = req.step_y;
      s1_word_in.step_z       = req.step_z;
      s1_word_in.second_x     = req.second_x;
      s1_word_in.second_y     = req.second_y;
      s1_word_in.second_z     = req.second_z;
      s1_word_in.linear_index = req.linear_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_word_ff <= s1_word_in;
      end
   end

   // stage 2: checks, move, distance magnitudes
   logic      s2_valid;
   front_type s2_word;

   plcu_front #(.SW(SW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_word   (s1_word_ff),
      .per       ({cfg_ff.wrap_z, cfg_ff.wrap_y, cfg_ff.wrap_x}),
      .nx        (nx),
      .ny        (ny),
      .nz        (nz),
      .out_valid (s2_valid),
      .out_word  (s2_word)
   );

   // stage 3: squares and index range pre-check
   logic               s3_valid_ff;
   mid_type            s3_word_ff, s3_word_in;
   logic [INDEX_W-1:0] s3_index_ff;

   always_comb begin
      s3_word_in.op     = s2_word.op;
      s3_word_in.status = s2_word.status;
      s3_word_in.ox     = s2_word.ox;
      s3_word_in.oy     = s2_word.oy;
      s3_word_in.oz     = s2_word.oz;
      s3_word_in.sq_x   = SQ_W'(s2_word.mag_x) * SQ_W'(s2_word.mag_x);
      s3_word_in.sq_y   = SQ_W'(s2_word.mag_y) * SQ_W'(s2_word.mag_y);
      s3_word_in.sq_z   = SQ_W'(s2_word.mag_z) * SQ_W'(s2_word.mag_z);
      // quotient would not fit the divider: certainly past the last plane
      s3_word_in.ovf    = OW'(s2_word.linear_index) >= (OW'(plane_ff) << SW);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_word_ff  <= s3_word_in;
         s3_index_ff <= s2_word.linear_index;
      end
   end

   // index / plane, then remainder / nz
   logic               d1_valid;
   logic [SW-1:0]      d1_quot;
   logic [INDEX_W-1:0] d1_rem;
   logic [SIDE1W-1:0]  d1_side;

   plcu_divider #(.QW(SW), .NW(INDEX_W), .DW(PW), .SIDE_W(SIDE1W)) u_div_plane (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .num       (s3_index_ff),
      .den       (plane_ff),
      .side_in   (SIDE1W'(s3_word_ff)),
      .out_valid (d1_valid),
      .quot      (d1_quot),
      .rem       (d1_rem),
      .side_out  (d1_side)
   );

   logic              d2_valid;
   logic [SW-1:0]     d2_quot;
   logic [PW-1:0]     d2_rem;
   logic [SIDE2W-1:0] d2_side;

   plcu_divider #(.QW(SW), .NW(PW), .DW(SW), .SIDE_W(SIDE2W)) u_div_row (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d1_valid),
      .num       (d1_rem[PW-1:0]),
      .den       (nz),
      .side_in   ({d1_side, d1_quot}),
      .out_valid (d2_valid),
      .quot      (d2_quot),
      .rem       (d2_rem),
      .side_out  (d2_side)
   );

   // stage E1: pick coordinates, index products, distance sum
   mid_type            m2;
   logic [SW-1:0]      q1;
   logic [CW-1:0]      cx, cy, cz;
   logic [1:0]         e1_status_in;
   logic [CW+PW-1:0]   p1_full;
   logic [2*CW-1:0]    p2_full;
   logic               e1_valid_ff;
   logic [1:0]         e1_op_ff, e1_status_ff;
   logic [COORD_W-1:0] e1_x_ff, e1_y_ff;
   logic [CW-1:0]      e1_z_ff;
   logic [INDEX_W-1:0] e1_p1_ff, e1_p2_ff;
   logic [DIST_W-1:0]  e1_dsum_ff, e1_dsum_in;

   assign m2 = mid_type'(d2_side[SIDE2W-1:SW]);
   assign q1 = d2_side[SW-1:0];

   always_comb begin
      if (m2.op == OP_TO_COORD) begin
         cx           = CW'(q1);
         cy           = CW'(d2_quot);
         cz           = CW'(d2_rem[SW-1:0]);
         e1_status_in = (m2.ovf || (q1 >= nx)) ? STAT_BAD_INDEX : STAT_OK;
      end else begin
         cx           = CW'(m2.ox);
         cy           = CW'(m2.oy);
         cz           = CW'(m2.oz);
         e1_status_in = m2.status;
      end
      p1_full    = (CW + PW)'(cx) * (CW + PW)'(plane_ff);
      p2_full    = (2 * CW)'(cy) * (2 * CW)'(nz);
      e1_dsum_in = DIST_W'(m2.sq_x) + DIST_W'(m2.sq_y) + DIST_W'(m2.sq_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (en) begin
         e1_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_op_ff     <= m2.op;
         e1_status_ff <= e1_status_in;
         e1_x_ff      <= cx[COORD_W-1:0];
         e1_y_ff      <= cy[COORD_W-1:0];
         e1_z_ff      <= cz;
         e1_p1_ff     <= INDEX_W'(p1_full);
         e1_p2_ff     <= INDEX_W'(p2_full);
         e1_dsum_ff   <= e1_dsum_in;
      end
   end

   // output register
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;

   always_comb begin
      rsp_status_in = e1_status_ff;
      rsp_x_in      = '0;
      rsp_y_in      = '0;
      rsp_z_in      = '0;
      rsp_index_in  = '0;
      rsp_dist_in   = '0;
      if (e1_status_ff == STAT_OK) begin
         if (e1_op_ff == OP_DIST) begin
            rsp_dist_in = e1_dsum_ff;
         end else begin
            rsp_x_in     = e1_x_ff;
            rsp_y_in     = e1_y_ff;
            rsp_z_in     = e1_z_ff[COORD_W-1:0];
            rsp_index_in = e1_p1_ff + e1_p2_ff + INDEX_W'(e1_z_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= e1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_status_ff <= rsp_status_in;
         rsp_x_ff      <= rsp_x_in;
         rsp_y_ff      <= rsp_y_in;
         rsp_z_ff      <= rsp_z_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_dist_ff   <= rsp_dist_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.out_x     = rsp_x_ff;
   assign rsp.out_y     = rsp_y_ff;
   assign rsp.out_z     = rsp_z_ff;
   assign rsp.out_index = rsp_index_ff;
   assign rsp.dist_sq   = rsp_dist_ff;

endmodule

`default_nettype wire

>>> sv/plcu_front.sv
// Front stage: lattice bounds checks, move with wrap, per-axis
// minimum-image distance magnitudes. One register stage. Depends on plcu_pkg.
`default_nettype none

module plcu_front #(
   parameter int SW = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  plcu_pkg::req_type  in_word,
   input  logic [2:0]         per,
   input  logic [SW-1:0]      nx,
   input  logic [SW-1:0]      ny,
   input  logic [SW-1:0]      nz,
   output logic               out_valid,
   output plcu_pkg::front_type out_word
);
   import plcu_pkg::*;

   localparam int CW = (SW > COORD_W) ? SW : COORD_W;
   localparam int TW = CW + 2;

   logic [COORD_W-1:0]   a [3];
   logic [COORD_W-1:0]   b [3];
   logic [STEP_W-1:0]    s [3];
   logic [SW-1:0]        n [3];
   logic signed [TW-1:0] ns [3];
   logic signed [TW-1:0] t_raw [3];
   logic signed [TW-1:0] t_wr [3];
   logic [COORD_W-1:0]   mv [3];
   logic [COORD_W-1:0]   d [3];
   logic [COORD_W-1:0]   mag [3];
   logic [2:0]           a_ok, b_ok, mv_ok;
   logic                 zero_step;
   logic                 valid_ff;
   front_type            word_ff, word_in;

   always_comb begin
      a[0] = in_word.first_x;  a[1] = in_word.first_y;  a[2] = in_word.first_z;
      b[0] = in_word.second_x; b[1] = in_word.second_y; b[2] = in_word.second_z;
      s[0] = in_word.step_x;   s[1] = in_word.step_y;   s[2] = in_word.step_z;
      n[0] = nx; n[1] = ny; n[2] = nz;
      for (int i = 0; i < 3; i++) begin
         a_ok[i]  = CW'(a[i]) < CW'(n[i]);
         b_ok[i]  = CW'(b[i]) < CW'(n[i]);
         ns[i]    = signed'(TW'(n[i]));
         t_raw[i] = signed'(TW'(a[i])) + TW'(signed'(s[i]));
         t_wr[i]  = t_raw[i];
         // periodic axes wrap by one lattice length only
         if (per[i]) begin
            if (t_raw[i] < 0) begin
               t_wr[i] = t_raw[i] + ns[i];
            end else if (t_raw[i] >= ns[i]) begin
               t_wr[i] = t_raw[i] - ns[i];
            end
         end
         mv_ok[i] = (t_wr[i] >= 0) && (t_wr[i] < ns[i]);
         mv[i]    = t_wr[i][COORD_W-1:0];
         d[i]     = (a[i] > b[i]) ? (a[i] - b[i]) : (b[i] - a[i]);
         // minimum image: magnitude n - d never exceeds d here
         if (per[i] && ((CW + 1)'({d[i], 1'b0}) > (CW + 1)'(n[i]))) begin
            mag[i] = COORD_W'(CW'(n[i]) - CW'(d[i]));
         end else begin
            mag[i] = d[i];
         end
      end
      zero_step = (s[0] == '0) && (s[1] == '0) && (s[2] == '0);

      word_in.op           = in_word.op;
      word_in.mag_x        = mag[0];
      word_in.mag_y        = mag[1];
      word_in.mag_z        = mag[2];
      word_in.linear_index = in_word.linear_index;
      word_in.ox           = a[0];
      word_in.oy           = a[1];
      word_in.oz           = a[2];
      unique case (in_word.op)
         OP_MOVE: begin
            word_in.ox = mv[0];
            word_in.oy = mv[1];
            word_in.oz = mv[2];
            if (!(&a_ok)) begin
               word_in.status = STAT_OUTSIDE;
            end else if (zero_step || !(&mv_ok)) begin
               word_in.status = STAT_REJECT;
            end else begin
               word_in.status = STAT_OK;
            end
         end
         OP_DIST: begin
            word_in.status = (&a_ok && &b_ok) ? STAT_OK : STAT_OUTSIDE;
         end
         OP_TO_COORD: begin
            word_in.status = STAT_OK;
         end
         OP_TO_INDEX: begin
            word_in.status = (&a_ok) ? STAT_OK : STAT_OUTSIDE;
         end
         default: begin
            word_in.status = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

>>> sv/plcu_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with a side
// word that travels alongside. No package dependency.
`default_nettype none

module plcu_divider #(
   parameter int QW     = 11,
   parameter int NW     = 30,
   parameter int DW     = 22,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NW-1:0]     num,
   input  logic [DW-1:0]     den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [QW-1:0]     quot,
   output logic [NW-1:0]     rem,
   output logic [SIDE_W-1:0] side_out
);

   localparam int WW = ((NW > DW + QW) ? NW : DW + QW) + 1;

   logic              valid_ff [QW];
   logic [NW-1:0]     rem_ff   [QW];
   logic [QW-1:0]     quot_ff  [QW];
   logic [SIDE_W-1:0] side_ff  [QW];

   for (genvar g = 0; g < QW; g++) begin : g_stage
      logic              v_prev;
      logic [NW-1:0]     r_prev;
      logic [QW-1:0]     q_prev;
      logic [SIDE_W-1:0] sd_prev;
      logic [WW-1:0]     trial;
      logic [NW-1:0]     rem_in;
      logic [QW-1:0]     quot_in;

      if (g == 0) begin : g_first
         assign v_prev  = in_valid;
         assign r_prev  = num;
         assign q_prev  = '0;
         assign sd_prev = side_in;
      end else begin : g_next
         assign v_prev  = valid_ff[g-1];
         assign r_prev  = rem_ff[g-1];
         assign q_prev  = quot_ff[g-1];
         assign sd_prev = side_ff[g-1];
      end

      assign trial = WW'(den) << (QW - 1 - g);

      always_comb begin
         if (WW'(r_prev) >= trial) begin
            rem_in  = r_prev - NW'(trial);
            quot_in = q_prev | (QW'(1) << (QW - 1 - g));
         end else begin
            rem_in  = r_prev;
            quot_in = q_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            quot_ff[g] <= quot_in;
            side_ff[g] <= sd_prev;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign quot      = quot_ff[QW-1];
   assign rem       = rem_ff[QW-1];
   assign side_out  = side_ff[QW-1];

endmodule

`default_nettype wire

>>> sv/plcu_checker.sv
// Port-level checker for the periodic lattice coordinate unit and its bind.
// Depends on plcu_pkg.
`default_nettype none

module plcu_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [1:0]                   rsp_status,
   input logic [plcu_pkg::COORD_W-1:0] rsp_out_x,
   input logic [plcu_pkg::INDEX_W-1:0] rsp_out_index,
   input logic [plcu_pkg::DIST_W-1:0]  rsp_dist_sq
);
   import plcu_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_out_index) && $stable(rsp_dist_sq))
      else $error("response word changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |->
         (rsp_out_x == '0) && (rsp_out_index == '0) && (rsp_dist_sq == '0))
      else $error("error response carries nonzero fields");

   a_dist_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_dist_sq != '0) |->
         (rsp_status == STAT_OK) && (rsp_out_x == '0) && (rsp_out_index == '0))
      else $error("distance response carries coordinates");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response stall");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind periodic_lattice_coordinate_unit plcu_checker u_plcu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_status    (rsp.status),
   .rsp_out_x     (rsp.out_x),
   .rsp_out_index (rsp.out_index),
   .rsp_dist_sq   (rsp.dist_sq)
);

`default_nettype wire

>>> dv/plcu_tb_if.sv
`timescale 1ns / 100ps
// Testbench-side notes: channel interfaces come from sv/plcu_if.sv.
// This file holds the word types used by the lattice testbench; depends on plcu_pkg.

package plcu_tb_pkg;
   import plcu_pkg::*;

   typedef struct {
      logic [1:0]         status;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic [COORD_W-1:0] out_z;
      logic [INDEX_W-1:0] out_index;
      logic [DIST_W-1:0]  dist_sq;
   } site_result_type;

   typedef struct {
      req_type         word;
      bit              has_fixed;
      site_result_type fixed;
   } stim_row_type;
endpackage

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for periodic_lattice_coordinate_unit: directed table plus
// random words, each response compared with a fixed table entry or an in-bench
// lattice predictor. Depends on plcu_pkg, plcu_if, plcu_tb_pkg and the RTL.

module tb_top;
   import plcu_pkg::*;
   import plcu_tb_pkg::*;

   localparam int LATENCY    = 4 + 2 * $clog2(1024 + 1);
   localparam int STALL_LIM  = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]    csr_wdata = '0;

   plcu_req_if req ();
   plcu_rsp_if rsp ();

   periodic_lattice_coordinate_unit u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // bench copy of the lattice registers
   int  dim_x = 1, dim_y = 1, dim_z = 1;
   bit  per_x = 0, per_y = 0, per_z = 0;

   site_result_type pending_results[$];
   int  failures = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_off = 0;
   int  quiet_cycles = 0;

   function automatic int clamp_dim(int s);
      if (s < 1) return 1;
      if (s > 1024) return 1024;
      return s;
   endfunction

   function automatic bit on_axis(int c, int n);
      return c >= 0 && c < n;
   endfunction

   function automatic bit step_axis(int c, int d, int n, bit per, output int dst);
      int t;
      t = c + d;
      dst = 0;
      if (per) begin
         if (t < 0) t += n;
         else if (t >= n) t -= n;
      end
      if (!on_axis(t, n)) return 0;
      dst = t;
      return 1;
   endfunction

   function automatic longint image_sq(int a, int b, int n, bit per);
      longint d;
      d = a > b ? a - b : b - a;
      if (per && 2 * d > n) d -= n;
      return d * d;
   endfunction

   function automatic site_result_type lattice_result(req_type w);
      site_result_type r;
      int ax, ay, az, bx, by, bz, sx, sy, sz, dx, dy, dz;
      longint plane, total, idx, ox, oy, oz, dsq;
      bit a_in, b_in;
      ax = w.first_x; ay = w.first_y; az = w.first_z;
      bx = w.second_x; by = w.second_y; bz = w.second_z;
      sx = $signed(w.step_x); sy = $signed(w.step_y); sz = $signed(w.step_z);
      a_in = on_axis(ax, dim_x) && on_axis(ay, dim_y) && on_axis(az, dim_z);
      r.status = STAT_OK;
      ox = 0; oy = 0; oz = 0; dsq = 0;
      case (w.op)
         OP_MOVE: begin
            if (!a_in) r.status = STAT_OUTSIDE;
            else if ((sx == 0 && sy == 0 && sz == 0) ||
                     !step_axis(ax, sx, dim_x, per_x, dx) ||
                     !step_axis(ay, sy, dim_y, per_y, dy) ||
                     !step_axis(az, sz, dim_z, per_z, dz))
               r.status = STAT_REJECT;
            else begin
               ox = dx; oy = dy; oz = dz;
            end
         end
         OP_DIST: begin
            b_in = on_axis(bx, dim_x) && on_axis(by, dim_y) && on_axis(bz, dim_z);
            if (!a_in || !b_in) r.status = STAT_OUTSIDE;
            else dsq = image_sq(ax, bx, dim_x, per_x) + image_sq(ay, by, dim_y, per_y)
                       + image_sq(az, bz, dim_z, per_z);
         end
         OP_TO_COORD: begin
            idx = w.linear_index;
            plane = longint'(dim_y) * dim_z;
            total = plane * dim_x;
            if (idx >= total) r.status = STAT_BAD_INDEX;
            else begin
               ox = idx / plane;
               oy = (idx % plane) / dim_z;
               oz = (idx % plane) % dim_z;
            end
         end
         default: begin
            if (!a_in) r.status = STAT_OUTSIDE;
            else begin
               ox = ax; oy = ay; oz = az;
            end
         end
      endcase
      r.out_x = ox; r.out_y = oy; r.out_z = oz;
      r.out_index = (r.status == STAT_OK && w.op != OP_DIST) ?
                    ox * dim_y * dim_z + oy * dim_z + oz : 0;
      r.dist_sq = dsq;
      return r;
   endfunction

   function automatic void expect_word(site_result_type r);
      pending_results.insert(pending_results.size(), r);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= SIZE_W'(val);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SIZE_X: dim_x = clamp_dim(val & 'h7FF);
         CSR_SIZE_Y: dim_y = clamp_dim(val & 'h7FF);
         CSR_SIZE_Z: dim_z = clamp_dim(val & 'h7FF);
         CSR_WRAP_X: per_x = val & 1;
         CSR_WRAP_Y: per_y = val & 1;
         default:    per_z = val & 1;
      endcase
   endtask

   task automatic set_lattice(int nx, int ny, int nz, bit wx, bit wy, bit wz);
      write_reg(CSR_SIZE_X, nx);
      write_reg(CSR_SIZE_Y, ny);
      write_reg(CSR_SIZE_Z, nz);
      write_reg(CSR_WRAP_X, wx);
      write_reg(CSR_WRAP_Y, wy);
      write_reg(CSR_WRAP_Z, wz);
   endtask

   // one word onto the request channel; valid may stay high into the next word
   task automatic send_word(req_type w);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      {req.op, req.first_x, req.first_y, req.first_z, req.step_x, req.step_y,
       req.step_z, req.second_x, req.second_y, req.second_z, req.linear_index} <= w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expect_word(lattice_result(w));
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic int pick_coord(int n);
      int u;
      u = $urandom_range(9);
      if (u == 0) return $urandom_range(1023);
      if (u == 1) return n;
      if (u == 2) return n - 1;
      return $urandom_range(n - 1);
   endfunction

   function automatic req_type random_word();
      req_type w;
      logic [31:0] noise;
      noise = $urandom();
      w = {$urandom(), $urandom(), $urandom(), $urandom()};
      w.op = $urandom_range(3);
      if (noise[3:0] != 0) begin
         w.first_x = pick_coord(dim_x);
         w.first_y = pick_coord(dim_y);
         w.first_z = pick_coord(dim_z);
         w.second_x = pick_coord(dim_x);
         w.second_y = pick_coord(dim_y);
         w.second_z = pick_coord(dim_z);
         if (noise[4]) w.linear_index = $urandom_range(
               longint'(dim_x) * dim_y * dim_z > 32'h7FFF_FFFF ? 32'h7FFF_FFFF :
               longint'(dim_x) * dim_y * dim_z);
      end
      return w;
   endfunction

   // response side: stalls plus the long hold-off
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= !hold_off && !(recv_stall_pct > 0 &&
                                      $urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      site_result_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response word");
            failures++;
         end else begin
            e = pending_results.pop_front();
            if (rsp.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp.status); failures++;
            end
            if (rsp.out_x !== e.out_x) begin
               $error("out_x exp %0d got %0d", e.out_x, rsp.out_x); failures++;
            end
            if (rsp.out_y !== e.out_y) begin
               $error("out_y exp %0d got %0d", e.out_y, rsp.out_y); failures++;
            end
            if (rsp.out_z !== e.out_z) begin
               $error("out_z exp %0d got %0d", e.out_z, rsp.out_z); failures++;
            end
            if (rsp.out_index !== e.out_index) begin
               $error("out_index exp %0d got %0d", e.out_index, rsp.out_index); failures++;
            end
            if (rsp.dist_sq !== e.dist_sq) begin
               $error("dist_sq exp %0d got %0d", e.dist_sq, rsp.dist_sq); failures++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIM) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic req_type mk(logic [1:0] op, int ax, int ay, int az,
                                  int sx, int sy, int sz, int bx, int by, int bz,
                                  longint li);
      req_type w;
      w.op = op; w.first_x = ax; w.first_y = ay; w.first_z = az;
      w.step_x = sx; w.step_y = sy; w.step_z = sz;
      w.second_x = bx; w.second_y = by; w.second_z = bz;
      w.linear_index = li;
      return w;
   endfunction

   function automatic site_result_type fx(logic [1:0] st);
      site_result_type r;
      r = '{st, 0, 0, 0, 0, 0};
      return r;
   endfunction

   initial begin
      stim_row_type rows[$];
      int phase;
      req.valid = 1'b0;
      {req.op, req.first_x, req.first_y, req.first_z, req.step_x, req.step_y,
       req.step_z, req.second_x, req.second_y, req.second_z, req.linear_index} = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // after reset: 1x1x1 open lattice
      rows.insert(rows.size(), '{mk(OP_TO_INDEX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                                 fx(STAT_OK)});
      rows.insert(rows.size(), '{mk(OP_MOVE, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0), 1,
                                 fx(STAT_REJECT)});
      rows.insert(rows.size(), '{mk(OP_TO_COORD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1,
                                 fx(STAT_BAD_INDEX)});
      rows.insert(rows.size(), '{mk(OP_DIST, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0), 1,
                                 fx(STAT_OUTSIDE)});
      foreach (rows[i]) begin
         send_word(rows[i].word);
         if (rows[i].has_fixed)
            pending_results[pending_results.size() - 1] = rows[i].fixed;
      end
      drain();

      // size 0 acts as 1, size above the maximum acts as the maximum
      set_lattice(2047, 0, 5, 1, 0, 1);
      rows.delete();
      rows.insert(rows.size(), '{mk(OP_TO_INDEX, 1023, 0, 4, 0, 0, 0, 0, 0, 0, 0), 0,
                                 fx(STAT_OK)});
      rows.insert(rows.size(), '{mk(OP_MOVE, 1023, 0, 4, 1, 0, 1, 0, 0, 0, 0), 0,
                                 fx(STAT_OK)});
      rows.insert(rows.size(), '{mk(OP_MOVE, 0, 0, 0, -15, 0, -15, 0, 0, 0, 0), 0,
                                 fx(STAT_OK)});
      rows.insert(rows.size(), '{mk(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                                 fx(STAT_REJECT)});
      rows.insert(rows.size(), '{mk(OP_MOVE, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1,
                                 fx(STAT_REJECT)});
      rows.insert(rows.size(), '{mk(OP_MOVE, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0), 1,
                                 fx(STAT_OUTSIDE)});
      rows.insert(rows.size(), '{mk(OP_MOVE, 5, 0, 2, 0, 0, 15, 0, 0, 0, 0), 1,
                                 fx(STAT_REJECT)});
      rows.insert(rows.size(), '{mk(OP_DIST, 0, 0, 0, 0, 0, 0, 1023, 0, 4, 0), 0,
                                 fx(STAT_OK)});
      rows.insert(rows.size(), '{mk(OP_DIST, 1023, 0, 4, 0, 0, 0, 1023, 0, 5, 0), 1,
                                 fx(STAT_OUTSIDE)});
      rows.insert(rows.size(), '{mk(OP_TO_COORD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5119), 0,
                                 fx(STAT_OK)});
      rows.insert(rows.size(), '{mk(OP_TO_COORD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5120), 1,
                                 fx(STAT_BAD_INDEX)});
      rows.insert(rows.size(), '{mk(OP_TO_COORD, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                    30'h3FFF_FFFF), 1, fx(STAT_BAD_INDEX)});
      rows.insert(rows.size(), '{mk(OP_TO_INDEX, 1023, 1023, 1023, 0, 0, 0, 0, 0, 0, 0),
                                 1, fx(STAT_OUTSIDE)});
      foreach (rows[i]) begin
         send_word(rows[i].word);
         if (rows[i].has_fixed)
            pending_results[pending_results.size() - 1] = rows[i].fixed;
      end
      drain();

      // largest lattice, all periodic: indices reach the top of the range
      set_lattice(1024, 1024, 1024, 1, 1, 1);
      send_word(mk(OP_TO_COORD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 30'h3FFF_FFFF));
      send_word(mk(OP_TO_INDEX, 1023, 1023, 1023, 0, 0, 0, 0, 0, 0, 0));
      send_word(mk(OP_DIST, 0, 0, 0, 0, 0, 0, 512, 512, 511, 0));
      send_word(mk(OP_MOVE, 1023, 0, 1023, 1, -1, 15, 0, 0, 0, 0));
      drain();

      // random phases over several lattices and idling profiles
      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         if (phase == 7) set_lattice(1024, 3, 1024, 0, 1, 0);
         else set_lattice($urandom_range(1, 40), $urandom_range(1, 40),
                          $urandom_range(1, 40), $urandom_range(1), $urandom_range(1),
                          $urandom_range(1));
         if (phase == 4) fork
            begin
               hold_off = 1;
               repeat (300) @(posedge clock);
               hold_off = 0;
            end
         join_none
         repeat (100) send_word(random_word());
         drain();
      end

      if (failures == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
